// ===== hdl/ed_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed_pkg: shared types and constants of the ElGamal decryption unit
// Item layouts, datapath operation codes, status group and register indexes.
// ----------------------------------------------------------------------------
package ed_pkg;

  localparam int MOD_BITS = 31;
  // Intermediate width: one bit above the modulus for sums below 2p.
  localparam int WIDE_BITS = MOD_BITS + 1;
  localparam int CNT_BITS = $clog2(MOD_BITS + 1);

  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(117);
  localparam logic [MOD_BITS-1:0] PRIV_KEY_RESET = '0;

  // Configuration register indexes.
  localparam logic CFG_MODULUS = 1'b0;
  localparam logic CFG_PRIVATE_KEY = 1'b1;

  typedef struct packed {
    logic [MOD_BITS-1:0] cipher_first;
    logic [MOD_BITS-1:0] cipher_second;
  } in_item_t;

  typedef struct packed {
    logic [MOD_BITS-1:0] plain_value;
    logic                no_inverse;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_RED1,
    OP_RED2,
    OP_MUL_AB,
    OP_SET_ACC,
    OP_MUL_BB,
    OP_SET_BASE,
    OP_INV_INIT,
    OP_EU_DIV,
    OP_EU_STEP,
    OP_EU_UPD,
    OP_FMUL,
    OP_OUT_OK,
    OP_OUT_BAD
  } dp_op_t;

  typedef struct packed {
    logic mul_busy;
    logic div_busy;
    logic e_zero;
    logic e_lsb;
    logic r1_zero;
    logic r0_one;
    logic p_small;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/ed_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed_datapath: registers and serial arithmetic units
// Holds configuration, the exponentiation and Euclid registers, a bit-serial
// modular multiplier, a restoring divider and the result register.
// ----------------------------------------------------------------------------
module ed_datapath import ed_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dp_op_t              op,
  input  wire in_item_t            in_data,
  input  wire logic                cfg_we,
  input  wire logic                cfg_index,
  input  wire logic [MOD_BITS-1:0] cfg_data,
  output dp_status_t               status,
  output out_item_t                out_data
);

  logic [MOD_BITS-1:0] p_r, x_r, e_r, acc_r, base_r, c2_r;
  logic [MOD_BITS-1:0] r0_r, r1_r, t0_r, t1_r;
  out_item_t out_r;

  // Multiplier state.
  logic [MOD_BITS-1:0] mx_r, my_r, prod_r;
  logic [CNT_BITS-1:0] mcnt_r;
  logic                mbusy_r;
  logic                mul_start;
  logic [MOD_BITS-1:0] mul_a, mul_b;

  // Divider state.
  logic [MOD_BITS-1:0] dn_r, dd_r, rem_r;
  logic [CNT_BITS-1:0] dcnt_r;
  logic                dbusy_r;
  logic                div_start;
  logic [MOD_BITS-1:0] div_n, div_d;

  logic [WIDE_BITS-1:0] m_dbl, m_dbl_red, m_add, m_add_red;
  logic [WIDE_BITS-1:0] d_shift;
  logic                 d_ge;
  logic [MOD_BITS-1:0]  q_red;
  logic [WIDE_BITS-1:0] t_sub;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= MODULUS_RESET;
      x_r <= PRIV_KEY_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MODULUS) p_r <= cfg_data;
      else x_r <= cfg_data;
    end
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_start = 1'b0;
    mul_a = acc_r;
    mul_b = base_r;
    div_start = 1'b0;
    div_n = in_data.cipher_first;
    div_d = p_r;
    case (op)
      OP_LOAD: begin
        div_start = 1'b1;
      end
      OP_RED1: begin
        div_start = 1'b1;
        div_n = c2_r;
      end
      OP_MUL_AB: begin
        mul_start = 1'b1;
      end
      OP_SET_ACC, OP_MUL_BB: begin
        mul_start = 1'b1;
        mul_a = base_r;
      end
      OP_EU_DIV: begin
        div_start = 1'b1;
        div_n = r0_r;
        div_d = r1_r;
      end
      OP_EU_STEP: begin
        mul_start = 1'b1;
        mul_a = q_red;
        mul_b = t1_r;
      end
      OP_FMUL: begin
        mul_start = 1'b1;
        mul_a = c2_r;
        mul_b = t0_r;
      end
      default: begin
      end
    endcase
  end

  // Multiplier step: double the partial product, then add on a set bit.
  always_comb begin
    m_dbl = {prod_r, 1'b0};
    m_dbl_red = (m_dbl >= {1'b0, p_r}) ? m_dbl - {1'b0, p_r} : m_dbl;
    m_add = my_r[MOD_BITS-1] ? m_dbl_red + {1'b0, mx_r} : m_dbl_red;
    m_add_red = (m_add >= {1'b0, p_r}) ? m_add - {1'b0, p_r} : m_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      mcnt_r <= '0;
    end else if (mul_start) begin
      mbusy_r <= 1'b1;
      mcnt_r <= CNT_BITS'(MOD_BITS);
    end else if (mbusy_r) begin
      mcnt_r <= mcnt_r - 1'b1;
      if (mcnt_r == CNT_BITS'(1)) mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_start) begin
      mx_r <= mul_a;
      my_r <= mul_b;
      prod_r <= '0;
    end else if (mbusy_r) begin
      prod_r <= m_add_red[MOD_BITS-1:0];
      my_r <= {my_r[MOD_BITS-2:0], 1'b0};
    end
  end

  // Restoring divider step: one quotient bit a cycle.
  always_comb begin
    d_shift = {rem_r, dn_r[MOD_BITS-1]};
    d_ge = d_shift >= {1'b0, dd_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r <= '0;
    end else if (div_start) begin
      dbusy_r <= 1'b1;
      dcnt_r <= CNT_BITS'(MOD_BITS);
    end else if (dbusy_r) begin
      dcnt_r <= dcnt_r - 1'b1;
      if (dcnt_r == CNT_BITS'(1)) dbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (div_start) begin
      dn_r <= div_n;
      dd_r <= div_d;
      rem_r <= '0;
    end else if (dbusy_r) begin
      rem_r <= d_ge ? MOD_BITS'(d_shift - {1'b0, dd_r}) : d_shift[MOD_BITS-1:0];
      dn_r <= {dn_r[MOD_BITS-2:0], d_ge};
    end
  end

  // The quotient can reach p only on the first Euclid step.
  assign q_red = (dn_r >= p_r) ? dn_r - p_r : dn_r;
  // Coefficient update t0 - q*t1 kept as a residue mod p.
  assign t_sub = (t0_r >= prod_r) ? {1'b0, t0_r} - {1'b0, prod_r}
                                  : {1'b0, t0_r} + {1'b0, p_r} - {1'b0, prod_r};

  // Working registers.
  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        c2_r <= in_data.cipher_second;
        e_r <= x_r;
        acc_r <= MOD_BITS'(1);
      end
      OP_RED1: base_r <= rem_r;
      OP_RED2: c2_r <= rem_r;
      OP_SET_ACC: acc_r <= prod_r;
      OP_SET_BASE: begin
        base_r <= prod_r;
        e_r <= {1'b0, e_r[MOD_BITS-1:1]};
      end
      OP_INV_INIT: begin
        r0_r <= p_r;
        r1_r <= acc_r;
        t0_r <= '0;
        t1_r <= MOD_BITS'(1);
      end
      OP_EU_STEP: begin
        r0_r <= r1_r;
        r1_r <= rem_r;
      end
      OP_EU_UPD: begin
        t0_r <= t1_r;
        t1_r <= t_sub[MOD_BITS-1:0];
      end
      OP_OUT_OK: begin
        out_r.plain_value <= prod_r;
        out_r.no_inverse <= 1'b0;
      end
      OP_OUT_BAD: begin
        out_r.plain_value <= '0;
        out_r.no_inverse <= 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign out_data = out_r;

  always_comb begin
    status.mul_busy = mbusy_r;
    status.div_busy = dbusy_r;
    status.e_zero = (e_r == '0);
    status.e_lsb = e_r[0];
    status.r1_zero = (r1_r == '0);
    status.r0_one = (r0_r == MOD_BITS'(1));
    status.p_small = (p_r < MOD_BITS'(2));
  end

endmodule
`default_nettype wire

// ===== hdl/ed_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ed_controller: sequencing state machine
// Steps through operand reduction, square-and-multiply, the Euclid loop and
// the final multiply, and owns the result valid flag.
// ----------------------------------------------------------------------------
module ed_controller import ed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire dp_status_t status,
  output dp_op_t          op
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_RED1     = 13'b0000000000010,
    S_RED2     = 13'b0000000000100,
    S_EXP_CHK  = 13'b0000000001000,
    S_EXP_MA   = 13'b0000000010000,
    S_EXP_SQ   = 13'b0000000100000,
    S_INV_INIT = 13'b0000001000000,
    S_EU_CHK   = 13'b0000010000000,
    S_EU_DIV   = 13'b0000100000000,
    S_EU_MUL   = 13'b0001000000000,
    S_FMUL     = 13'b0010000000000,
    S_EMIT_OK  = 13'b0100000000000,
    S_EMIT_BAD = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  // Next state and operation select.
  always_comb begin
    state_nxt = state_r;
    op = OP_NONE;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (status.p_small) begin
            state_nxt = S_EMIT_BAD;
          end else begin
            op = OP_LOAD;
            state_nxt = S_RED1;
          end
        end
      end
      S_RED1: begin
        if (!status.div_busy) begin
          op = OP_RED1;
          state_nxt = S_RED2;
        end
      end
      S_RED2: begin
        if (!status.div_busy) begin
          op = OP_RED2;
          state_nxt = S_EXP_CHK;
        end
      end
      S_EXP_CHK: begin
        if (status.e_zero) begin
          state_nxt = S_INV_INIT;
        end else if (status.e_lsb) begin
          op = OP_MUL_AB;
          state_nxt = S_EXP_MA;
        end else begin
          op = OP_MUL_BB;
          state_nxt = S_EXP_SQ;
        end
      end
      S_EXP_MA: begin
        if (!status.mul_busy) begin
          op = OP_SET_ACC;
          state_nxt = S_EXP_SQ;
        end
      end
      S_EXP_SQ: begin
        if (!status.mul_busy) begin
          op = OP_SET_BASE;
          state_nxt = S_EXP_CHK;
        end
      end
      S_INV_INIT: begin
        op = OP_INV_INIT;
        state_nxt = S_EU_CHK;
      end
      S_EU_CHK: begin
        if (!status.r1_zero) begin
          op = OP_EU_DIV;
          state_nxt = S_EU_DIV;
        end else if (status.r0_one) begin
          op = OP_FMUL;
          state_nxt = S_FMUL;
        end else begin
          state_nxt = S_EMIT_BAD;
        end
      end
      S_EU_DIV: begin
        if (!status.div_busy) begin
          op = OP_EU_STEP;
          state_nxt = S_EU_MUL;
        end
      end
      S_EU_MUL: begin
        if (!status.mul_busy) begin
          op = OP_EU_UPD;
          state_nxt = S_EU_CHK;
        end
      end
      S_FMUL: begin
        if (!status.mul_busy) state_nxt = S_EMIT_OK;
      end
      S_EMIT_OK: begin
        if (slot_free) begin
          op = OP_OUT_OK;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_EMIT_BAD: begin
        if (slot_free) begin
          op = OP_OUT_BAD;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/elgamal_decrypt_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// elgamal_decrypt_unit: ElGamal decryption top level
// Recovers m = c2 * (c1^x)^-1 mod p, or flags a c1^x with no inverse mod p.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake              Payload
// in       in   in_valid / in_ready    in_data: cipher_first, cipher_second
// out      out  out_valid / out_ready  out_data: plain_value, no_inverse
// cfg      in   cfg_valid / cfg_ready  cfg_index (0 modulus, 1 key), cfg_data
//
// Each item runs bit-serial modular multiplies and restoring divides: one or
// two multiplies per exponent bit and one divide plus one multiply per Euclid
// step. One item is in work at a time.
// A finished item waits in the output register while the next one starts.
// Reset clears the controller; modulus resets to 117, key to 0.
// ----------------------------------------------------------------------------
module elgamal_decrypt_unit import ed_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_data,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic                cfg_index,
  input  wire logic [MOD_BITS-1:0] cfg_data
);

  dp_op_t     op;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  ed_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .op        (op)
  );

  ed_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .in_data   (in_data),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
